### hdl/rst_pkg.sv
// Package for the subscription table: sizes, action and event codes, payload structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rst_pkg;
    localparam int NUM_CLIENTS = 16;
    localparam int NUM_TOPICS  = 64;
    localparam int CW = 4;
    localparam int TW = 6;
    localparam int AW = 7;

    localparam logic [1:0] ACT_SUB   = 2'd0;
    localparam logic [1:0] ACT_UNSUB = 2'd1;
    localparam logic [1:0] ACT_RMCL  = 2'd2;
    localparam logic [1:0] ACT_QUERY = 2'd3;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_ADDED   = 2'd1;
    localparam logic [1:0] EV_REMOVED = 2'd2;

    typedef struct packed {
        logic [1:0]    action;
        logic [CW-1:0] client_id;
        logic [TW-1:0] topic_id;
    } t_req;

    typedef struct packed {
        logic [1:0]    event_res;
        logic [TW-1:0] topic_out;
        logic          is_member;
        logic [AW-1:0] active_topics;
        logic          last;
    } t_res;

    // command broadcast to every cell
    typedef struct packed {
        logic          op_sub;
        logic          op_unsub;
        logic          op_clr;
        logic [CW-1:0] client;
        logic [TW-1:0] topic;
    } t_cmd;
endpackage
`default_nettype wire

### hdl/rst_cell.sv
// One topic's membership cell; passes a sweep token to its neighbor.
// Depends on rst_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rst_cell (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire [rst_pkg::TW-1:0]    i_idx,
    input  wire rst_pkg::t_cmd       i_cmd,
    input  wire                      i_tok,
    input  wire                      i_hold,
    output logic                     o_tok,
    output logic                     o_hit,
    output logic                     o_has,
    output logic                     o_empty,
    output logic                     o_any
);
    import rst_pkg::*;
    logic [NUM_CLIENTS-1:0] r_bits, n_bits, w_bit;
    logic                   r_tok;

    assign w_bit   = NUM_CLIENTS'(1) << i_cmd.client;
    assign o_has   = |(r_bits & w_bit);
    assign o_any   = |r_bits;
    assign o_empty = (r_bits & ~w_bit) == '0;
    assign o_hit   = r_tok && o_has && o_empty;
    assign o_tok   = r_tok;

    always_comb begin
        n_bits = r_bits;
        if (i_cmd.topic == i_idx && i_cmd.op_sub) n_bits = r_bits | w_bit;
        if (i_cmd.topic == i_idx && i_cmd.op_unsub) n_bits = r_bits & ~w_bit;
        if (i_cmd.op_clr && r_tok && !i_hold) n_bits = r_bits & ~w_bit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
            r_tok  <= 1'b0;
        end else begin
            r_bits <= n_bits;
            if (!i_hold) r_tok <= i_tok;
        end
    end
endmodule
`default_nettype wire

### hdl/refcounted_subscription_table.sv
// Top level: a chain of topic cells with a token-driven remove-client sweep.
// Depends on rst_pkg and rst_cell.
//
// channel  dir  handshake          payload
// req      in   i_valid/o_stall    i_req (t_req)
// res      out  o_valid/i_stall    o_res (t_res)
//
// Subscribe, unsubscribe, query: accept in S_IDLE, then the result register is loaded from S_ONE.
// Remove client: a start step, then a token walks the chain one cell per cycle while no
// result is held stalled, then a final step in S_END.
// Removals are emitted one hit late so the final one can carry last.
// Reset clears all membership.
// A held result stalls the sweep; o_stall is high whenever the FSM is outside S_IDLE.
`timescale 1ns / 1ps
`default_nettype none
module refcounted_subscription_table (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_stall,
    input  wire rst_pkg::t_req    i_req,
    output logic                  o_valid,
    input  wire                   i_stall,
    output rst_pkg::t_res         o_res
);
    import rst_pkg::*;
    localparam logic [1:0] S_IDLE = 2'd0, S_ONE = 2'd1, S_SWP = 2'd2, S_END = 2'd3;

    logic [1:0]    r_st, n_st;
    t_req          r_req, n_req;
    logic [AW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_act, n_act;
    logic          r_emit, n_emit;
    logic          r_ov, n_ov;
    t_res          r_res, n_res;
    t_res          r_pend, n_pend;
    t_cmd          w_cmd;
    logic          w_hold, w_start, w_cv, w_tv;
    logic [NUM_TOPICS:0]   w_tok;
    logic [NUM_TOPICS-1:0] w_hit, w_has, w_emp, w_any;
    logic          w_hit_any, w_last;
    logic [TW-1:0] w_hit_idx;
    t_res          w_one;

    assign w_cv    = 32'(r_req.client_id) < NUM_CLIENTS;
    assign w_tv    = 32'(r_req.topic_id) < NUM_TOPICS;
    assign o_stall = r_st != S_IDLE;
    assign o_valid = r_ov;
    assign o_res   = r_res;
    assign w_hold  = r_ov && i_stall;
    assign w_start = (r_st == S_SWP) && !w_hold && r_cnt == '1;

    always_comb begin
        w_cmd.client   = r_req.client_id;
        w_cmd.topic    = r_req.topic_id;
        w_cmd.op_sub   = r_st == S_ONE && !w_hold && w_cv && w_tv && r_req.action == ACT_SUB;
        w_cmd.op_unsub = r_st == S_ONE && !w_hold && w_cv && w_tv &&
                         r_req.action == ACT_UNSUB;
        w_cmd.op_clr   = r_st == S_SWP && w_cv;
    end

    assign w_tok[0] = w_start;
    genvar g;
    generate
        for (g = 0; g < NUM_TOPICS; g++) begin : g_cell
            rst_cell u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_idx(TW'(g)), .i_cmd(w_cmd),
                .i_tok(w_tok[g]), .i_hold(w_hold), .o_tok(w_tok[g+1]),
                .o_hit(w_hit[g]), .o_has(w_has[g]), .o_empty(w_emp[g]), .o_any(w_any[g])
            );
        end
    endgenerate

    // only one token is live, so an OR-reduced index suffices
    always_comb begin
        w_hit_any = w_cv && |w_hit;
        w_hit_idx = '0;
        for (int k = 0; k < NUM_TOPICS; k++)
            if (w_hit[k]) w_hit_idx = w_hit_idx | TW'(k);
        w_last = w_tok[NUM_TOPICS];
    end

    always_comb begin
        w_one = r_res;
        w_one.last = 1'b1;
        w_one.is_member = 1'b0;
        w_one.event_res = EV_NONE;
        w_one.topic_out = r_req.topic_id;
        w_one.active_topics = r_cnt;
        if (w_cv && w_tv) begin
            case (r_req.action)
                ACT_SUB: begin
                    w_one.is_member = 1'b1;
                    if (!w_has[r_req.topic_id] && !w_any[r_req.topic_id]) begin
                        w_one.event_res = EV_ADDED;
                        w_one.active_topics = r_cnt + AW'(1);
                    end
                end
                ACT_UNSUB: begin
                    if (w_has[r_req.topic_id] && w_emp[r_req.topic_id]) begin
                        w_one.event_res = EV_REMOVED;
                        w_one.active_topics = r_cnt - AW'(1);
                    end
                end
                ACT_QUERY: w_one.is_member = w_has[r_req.topic_id];
                default: ;
            endcase
        end
    end

    // r_cnt doubles as the sweep-start flag (all ones) only while S_SWP begins
    always_comb begin
        n_st   = r_st;
        n_req  = r_req;
        n_cnt  = r_cnt;
        n_act  = r_act;
        n_emit = r_emit;
        n_ov   = r_ov && i_stall;
        n_res  = r_res;
        n_pend = r_pend;
        case (r_st)
            S_IDLE: begin
                if (i_valid) begin
                    n_req  = i_req;
                    n_emit = 1'b0;
                    if (i_req.action == ACT_RMCL) begin
                        n_st  = S_SWP;
                        n_cnt = '1;
                    end else begin
                        n_st  = S_ONE;
                        n_cnt = r_act;
                    end
                end
            end
            S_ONE: begin
                if (!w_hold) begin
                    n_res = w_one;
                    n_ov  = 1'b1;
                    n_act = w_one.active_topics;
                    n_st  = S_IDLE;
                end
            end
            S_SWP: begin
                if (!w_hold) begin
                    if (w_start) n_cnt = '0;
                    if (w_hit_any) begin
                        n_act = r_act - AW'(1);
                        n_pend.event_res = EV_REMOVED;
                        n_pend.topic_out = w_hit_idx;
                        n_pend.is_member = 1'b0;
                        n_pend.active_topics = r_act - AW'(1);
                        n_pend.last = 1'b0;
                        n_emit = 1'b1;
                        if (r_emit) begin
                            n_res = r_pend;
                            n_ov  = 1'b1;
                        end
                    end
                    if (w_last) n_st = S_END;
                end
            end
            S_END: begin
                if (!w_hold) begin
                    n_res.event_res = EV_NONE;
                    n_res.topic_out = '0;
                    n_res.is_member = 1'b0;
                    n_res.active_topics = r_act;
                    n_res.last = 1'b1;
                    if (r_emit) begin
                        n_res = r_pend;
                        n_res.last = 1'b1;
                    end
                    n_ov   = 1'b1;
                    n_emit = 1'b0;
                    n_st   = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_req  <= '0;
            r_ov   <= 1'b0;
            r_act  <= '0;
            r_cnt  <= '0;
            r_emit <= 1'b0;
            r_res  <= '0;
            r_pend <= '0;
        end else begin
            r_st   <= n_st;
            r_req  <= n_req;
            r_ov   <= n_ov;
            r_act  <= n_act;
            r_cnt  <= n_cnt;
            r_emit <= n_emit;
            r_res  <= n_res;
            r_pend <= n_pend;
        end
    end
endmodule
`default_nettype wire

### tb/tb.sv
// Testbench for refcounted_subscription_table: queue-fed driver, clocked monitor,
// in-bench membership predictor. Depends on rst_pkg and the table RTL.
`timescale 1ns / 1ps
module tb;
    import rst_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_req i_req;
    logic o_valid;
    logic i_stall;
    t_res o_res;

    refcounted_subscription_table uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_req(i_req), .o_valid(o_valid), .i_stall(i_stall), .o_res(o_res)
    );

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;

    logic [NUM_CLIENTS-1:0] members [NUM_TOPICS] = '{default: '0};
    int unsigned topic_count = 0;
    t_req pending_reqs[$];
    t_res expected_res[$];
    int errors = 0;
    int idle_pct;
    int stall_pct;
    int hold_cnt;
    bit hold_go;
    bit hold_used;
    int quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_res mk_res(logic [1:0] ev, logic [TW-1:0] tp, logic mem,
                                    logic lst);
        t_res r;
        r.event_res = ev;
        r.topic_out = tp;
        r.is_member = mem;
        r.active_topics = AW'(topic_count);
        r.last = lst;
        return r;
    endfunction

    task automatic predict_table(input t_req q);
        int n;
        logic [1:0] ev;
        logic cl_ok;
        logic tp_ok;
        n = 0;
        ev = EV_NONE;
        cl_ok = q.client_id < NUM_CLIENTS;
        tp_ok = q.topic_id < NUM_TOPICS;
        if (q.action == ACT_RMCL) begin
            if (cl_ok) begin
                for (int t = 0; t < NUM_TOPICS && t < 64; t++) begin
                    if (members[t][q.client_id]) begin
                        members[t][q.client_id] = 1'b0;
                        if (members[t] == '0) begin
                            if (topic_count > 0) topic_count--;
                            expected_res.push_back(mk_res(EV_REMOVED, TW'(t), 1'b0, 1'b0));
                            n++;
                        end
                    end
                end
            end
            if (n == 0) expected_res.push_back(mk_res(EV_NONE, '0, 1'b0, 1'b1));
            else expected_res[$].last = 1'b1;
        end else if (!cl_ok || !tp_ok) begin
            expected_res.push_back(mk_res(EV_NONE, q.topic_id, 1'b0, 1'b1));
        end else if (q.action == ACT_SUB) begin
            if (!members[q.topic_id][q.client_id]) begin
                if (members[q.topic_id] == '0) begin
                    ev = EV_ADDED;
                    if (topic_count < 127) topic_count++;
                end
                members[q.topic_id][q.client_id] = 1'b1;
            end
            expected_res.push_back(mk_res(ev, q.topic_id, 1'b1, 1'b1));
        end else if (q.action == ACT_UNSUB) begin
            if (members[q.topic_id][q.client_id]) begin
                members[q.topic_id][q.client_id] = 1'b0;
                if (members[q.topic_id] == '0) begin
                    ev = EV_REMOVED;
                    if (topic_count > 0) topic_count--;
                end
            end
            expected_res.push_back(mk_res(ev, q.topic_id, 1'b0, 1'b1));
        end else begin
            expected_res.push_back(mk_res(EV_NONE, q.topic_id,
                                          members[q.topic_id][q.client_id], 1'b1));
        end
    endtask

    function automatic t_req mk_req(logic [1:0] a, int c, int t);
        t_req q;
        q.action = a;
        q.client_id = CW'(c);
        q.topic_id = TW'(t);
        return q;
    endfunction

    // favor a small working set so topics fill and empty often
    function automatic t_req rand_req();
        int r;
        logic [1:0] a;
        r = $urandom_range(0, 99);
        if (r < 45) a = ACT_SUB;
        else if (r < 75) a = ACT_UNSUB;
        else if (r < 85) a = ACT_RMCL;
        else a = ACT_QUERY;
        if ($urandom_range(0, 3) == 0)
            return mk_req(a, $urandom_range(0, 15), $urandom_range(0, 63));
        return mk_req(a, $urandom_range(0, 3), $urandom_range(0, 7));
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_req <= '0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) predict_table(i_req);
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                i_valid <= 1'b1;
                i_req <= pending_reqs.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            hold_cnt <= 0;
            hold_used <= 1'b0;
        end else if (hold_go && !hold_used) begin
            if (hold_cnt == HOLD_CYCLES - 1) hold_used <= 1'b1;
            hold_cnt <= hold_cnt + 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_res.size() == 0) begin
                $display("%0t: unexpected transaction %p", $time, o_res);
                errors++;
            end else begin
                t_res e;
                e = expected_res.pop_front();
                if (o_res !== e) begin
                    $display("%0t: mismatch expected %p actual %p", $time, e, o_res);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic run_phase(input int idle, input int stall, input int count);
        idle_pct = idle;
        stall_pct = stall;
        for (int k = 0; k < count; k++) pending_reqs.push_back(rand_req());
        while (pending_reqs.size() > 0 || i_valid) @(posedge i_clk);
    endtask

    initial begin
        idle_pct = 0;
        stall_pct = 0;
        hold_go = 1'b0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        pending_reqs.push_back(mk_req(ACT_QUERY, 0, 0));
        pending_reqs.push_back(mk_req(ACT_SUB, 0, 0));
        pending_reqs.push_back(mk_req(ACT_SUB, 0, 0));
        pending_reqs.push_back(mk_req(ACT_SUB, 15, 63));
        pending_reqs.push_back(mk_req(ACT_SUB, 15, 0));
        pending_reqs.push_back(mk_req(ACT_QUERY, 15, 0));
        pending_reqs.push_back(mk_req(ACT_UNSUB, 0, 0));
        pending_reqs.push_back(mk_req(ACT_UNSUB, 3, 0));
        pending_reqs.push_back(mk_req(ACT_SUB, 15, 42));
        pending_reqs.push_back(mk_req(ACT_SUB, 5, 21));
        pending_reqs.push_back(mk_req(ACT_RMCL, 0, 0));
        while (pending_reqs.size() > 0 || i_valid) @(posedge i_clk);

        run_phase(0, 0, 60);
        run_phase(57, 0, 50);
        run_phase(0, 57, 50);
        hold_go = 1'b1;
        run_phase(15, 15, 60);

        while (expected_res.size() > 0) @(posedge i_clk);
        repeat (NUM_TOPICS + 10) @(posedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
